// ===== rtl/gbdec_pkg.sv =====
// Package for the SM83 opcode decoder: result record, operation class codes
// and the single-pass decode function. No dependencies.
`default_nettype none

package gbdec_pkg;

    localparam int unsigned OPC_W   = 8;
    localparam int unsigned CLASS_W = 7;
    localparam int unsigned SEL_W   = 3;
    localparam int unsigned PAIR_W  = 2;
    localparam int unsigned COND_W  = 2;

    // Operation classes, numbered in decoder order
    localparam logic [CLASS_W-1:0] CL_NOP        = 7'd0;
    localparam logic [CLASS_W-1:0] CL_JR_CC      = 7'd4;
    localparam logic [CLASS_W-1:0] CL_LD_RP_NN   = 7'd5;
    localparam logic [CLASS_W-1:0] CL_ADD_HL_RP  = 7'd6;
    localparam logic [CLASS_W-1:0] CL_ST_RP_A    = 7'd7;
    localparam logic [CLASS_W-1:0] CL_ST_HLI_A   = 7'd8;
    localparam logic [CLASS_W-1:0] CL_ST_HLD_A   = 7'd9;
    localparam logic [CLASS_W-1:0] CL_LD_A_RP    = 7'd10;
    localparam logic [CLASS_W-1:0] CL_LD_A_HLI   = 7'd11;
    localparam logic [CLASS_W-1:0] CL_LD_A_HLD   = 7'd12;
    localparam logic [CLASS_W-1:0] CL_INC_RP     = 7'd13;
    localparam logic [CLASS_W-1:0] CL_DEC_RP     = 7'd14;
    localparam logic [CLASS_W-1:0] CL_INC_R      = 7'd15;
    localparam logic [CLASS_W-1:0] CL_DEC_R      = 7'd17;
    localparam logic [CLASS_W-1:0] CL_LD_R_N     = 7'd19;
    localparam logic [CLASS_W-1:0] CL_RLCA       = 7'd21;
    localparam logic [CLASS_W-1:0] CL_HALT       = 7'd29;
    localparam logic [CLASS_W-1:0] CL_LD_R_MHL   = 7'd30;
    localparam logic [CLASS_W-1:0] CL_LD_MHL_R   = 7'd31;
    localparam logic [CLASS_W-1:0] CL_LD_R_R     = 7'd32;
    localparam logic [CLASS_W-1:0] CL_ALU_MEM_N  = 7'd33;
    localparam logic [CLASS_W-1:0] CL_ALU_R      = 7'd34;
    localparam logic [CLASS_W-1:0] CL_RET_CC     = 7'd35;
    localparam logic [CLASS_W-1:0] CL_POP        = 7'd40;
    localparam logic [CLASS_W-1:0] CL_RET        = 7'd41;
    localparam logic [CLASS_W-1:0] CL_JP_CC      = 7'd45;
    localparam logic [CLASS_W-1:0] CL_JP_NN      = 7'd50;
    localparam logic [CLASS_W-1:0] CL_CB_PREFIX  = 7'd51;
    localparam logic [CLASS_W-1:0] CL_DI         = 7'd52;
    localparam logic [CLASS_W-1:0] CL_EI         = 7'd53;
    localparam logic [CLASS_W-1:0] CL_CALL_CC    = 7'd54;
    localparam logic [CLASS_W-1:0] CL_PUSH       = 7'd55;
    localparam logic [CLASS_W-1:0] CL_CALL_NN    = 7'd56;
    localparam logic [CLASS_W-1:0] CL_RST        = 7'd57;
    localparam logic [CLASS_W-1:0] CL_CB_MEM     = 7'd58;
    localparam logic [CLASS_W-1:0] CL_CB_REG     = 7'd62;
    localparam logic [CLASS_W-1:0] CL_UNDEF      = 7'd66;

    localparam logic [SEL_W-1:0] R_MHL = 3'd6;
    localparam logic [SEL_W-1:0] R_A   = 3'd7;

    // Packed so that op_class lands in the lowest bits
    typedef struct packed {
        logic               undefined;
        logic               mem_operand;
        logic [SEL_W-1:0]   bit_index;
        logic [SEL_W-1:0]   sub_op;
        logic [COND_W-1:0]  cond;
        logic [PAIR_W-1:0]  pair_sel;
        logic [SEL_W-1:0]   src_sel;
        logic [SEL_W-1:0]   dst_sel;
        logic [CLASS_W-1:0] op_class;
    } t_dec_result;

    localparam int unsigned RES_W   = $bits(t_dec_result);
    localparam int unsigned TDATA_W = ((RES_W + 7) / 8) * 8;

    function automatic t_dec_result gbdec_decode(
        input logic [OPC_W-1:0] opcode,
        input logic             cb_page
    );
        t_dec_result       d;
        logic [1:0]        x;
        logic [2:0]        y;
        logic [2:0]        z;
        logic [1:0]        p;
        logic              q;
        logic [CLASS_W-1:0] base;
        x = opcode[7:6];
        y = opcode[5:3];
        z = opcode[2:0];
        p = opcode[5:4];
        q = opcode[3];
        d = '0;
        d.op_class = CL_UNDEF;
        base = CL_NOP;

        if (cb_page) begin
            base        = (z == R_MHL) ? CL_CB_MEM : CL_CB_REG;
            d.op_class  = base + CLASS_W'(x);
            d.dst_sel   = z;
            d.src_sel   = z;
            d.mem_operand = (z == R_MHL);
            if (x == 2'd0) begin
                d.sub_op = y;
            end else begin
                d.bit_index = y;
            end
        end else begin
            case (x)
                2'd0: begin
                    case (z)
                        3'd0: begin
                            if (y[2]) begin
                                d.op_class = CL_JR_CC;
                                d.cond     = y[1:0];
                            end else begin
                                d.op_class = CLASS_W'(y);
                            end
                        end
                        3'd1: begin
                            d.op_class = q ? CL_ADD_HL_RP : CL_LD_RP_NN;
                            d.pair_sel = p;
                        end
                        3'd2: begin
                            if (!q) begin
                                d.src_sel = R_A;
                                if (!p[1]) begin
                                    d.op_class = CL_ST_RP_A;
                                    d.pair_sel = p;
                                end else begin
                                    d.op_class    = p[0] ? CL_ST_HLD_A : CL_ST_HLI_A;
                                    d.mem_operand = 1'b1;
                                end
                            end else begin
                                d.dst_sel = R_A;
                                if (!p[1]) begin
                                    d.op_class = CL_LD_A_RP;
                                    d.pair_sel = p;
                                end else begin
                                    d.op_class    = p[0] ? CL_LD_A_HLD : CL_LD_A_HLI;
                                    d.mem_operand = 1'b1;
                                end
                            end
                        end
                        3'd3: begin
                            d.op_class = q ? CL_DEC_RP : CL_INC_RP;
                            d.pair_sel = p;
                        end
                        3'd4, 3'd5, 3'd6: begin
                            base = (z == 3'd4) ? CL_INC_R :
                                   (z == 3'd5) ? CL_DEC_R : CL_LD_R_N;
                            d.dst_sel = y;
                            // (HL) variant sits one above the register form
                            if (y == R_MHL) begin
                                d.op_class    = base + 7'd1;
                                d.mem_operand = 1'b1;
                            end else begin
                                d.op_class = base;
                            end
                        end
                        default: begin
                            d.op_class = CL_RLCA + CLASS_W'(y);
                            d.dst_sel  = R_A;
                            d.sub_op   = y;
                        end
                    endcase
                end
                2'd1: begin
                    if (y == R_MHL && z == R_MHL) begin
                        d.op_class = CL_HALT;
                    end else begin
                        d.dst_sel = y;
                        d.src_sel = z;
                        if (z == R_MHL) begin
                            d.op_class    = CL_LD_R_MHL;
                            d.mem_operand = 1'b1;
                        end else if (y == R_MHL) begin
                            d.op_class    = CL_LD_MHL_R;
                            d.mem_operand = 1'b1;
                        end else begin
                            d.op_class = CL_LD_R_R;
                        end
                    end
                end
                2'd2: begin
                    d.dst_sel = R_A;
                    d.src_sel = z;
                    d.sub_op  = y;
                    if (z == R_MHL) begin
                        d.op_class    = CL_ALU_MEM_N;
                        d.mem_operand = 1'b1;
                    end else begin
                        d.op_class = CL_ALU_R;
                    end
                end
                default: begin
                    case (z)
                        3'd0: begin
                            if (!y[2]) begin
                                d.op_class = CL_RET_CC;
                                d.cond     = y[1:0];
                            end else begin
                                d.op_class = CL_LD_R_R + CLASS_W'(y);
                                if (y == 3'd6) d.dst_sel = R_A;
                                if (y == 3'd4) d.src_sel = R_A;
                            end
                        end
                        3'd1: begin
                            if (!q) begin
                                d.op_class = CL_POP;
                                d.pair_sel = p;
                            end else begin
                                d.op_class = CL_RET + CLASS_W'(p);
                            end
                        end
                        3'd2: begin
                            if (!y[2]) begin
                                d.op_class = CL_JP_CC;
                                d.cond     = y[1:0];
                            end else begin
                                d.op_class = CL_RET + 7'd1 + CLASS_W'(y);
                                if (!y[1]) begin
                                    d.src_sel = R_A;
                                end else begin
                                    d.dst_sel = R_A;
                                end
                            end
                        end
                        3'd3: begin
                            case (y)
                                3'd0:    d.op_class = CL_JP_NN;
                                3'd1:    d.op_class = CL_CB_PREFIX;
                                3'd6:    d.op_class = CL_DI;
                                3'd7:    d.op_class = CL_EI;
                                default: d.undefined = 1'b1;
                            endcase
                        end
                        3'd4: begin
                            if (!y[2]) begin
                                d.op_class = CL_CALL_CC;
                                d.cond     = y[1:0];
                            end else begin
                                d.undefined = 1'b1;
                            end
                        end
                        3'd5: begin
                            if (!q) begin
                                d.op_class = CL_PUSH;
                                d.pair_sel = p;
                            end else if (p == 2'd0) begin
                                d.op_class = CL_CALL_NN;
                            end else begin
                                d.undefined = 1'b1;
                            end
                        end
                        3'd6: begin
                            d.op_class = CL_ALU_MEM_N;
                            d.dst_sel  = R_A;
                            d.sub_op   = y;
                        end
                        default: begin
                            d.op_class = CL_RST;
                            d.sub_op   = y;
                        end
                    endcase
                end
            endcase
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gb_cpu_opcode_decoder_top.sv =====
// SM83 opcode decoder top level: decode stage with output register and skid
// register. Depends on gbdec_pkg.
//
// Usage:
//   Slave channel: one opcode byte per item in i_s_tdata, i_s_tuser set when
//   the byte follows a CB prefix. Master channel: one decoded item per input
//   item, fields packed in o_m_tdata (see port comment).
//   Output: each result is registered (output or skid register). Throughput:
//   one item per cycle while the receiver takes items, set by the single
//   decode stage; the decode itself is a shallow table of the opcode bit fields.
//   Stall: when the receiver holds o_m_tready low, the output register keeps
//   its item and one more item is caught in the skid register; o_s_tready
//   drops only while the skid register is full, and the block resumes at
//   full rate as soon as the receiver takes items again.
//   Reset: i_rst_n low (synchronous) empties both registers and holds
//   o_s_tready low; no item is presented and the block is ready as soon as
//   reset is released. There is no other state and no configuration.
`default_nettype none

module gb_cpu_opcode_decoder_top (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_tvalid,
    output logic                             o_s_tready,
    input  wire  [gbdec_pkg::OPC_W-1:0]      i_s_tdata,  // [7:0] opcode
    input  wire                              i_s_tuser,  // [0] cb_page
    output logic                             o_m_tvalid,
    input  wire                              i_m_tready,
    // [6:0] op_class, [9:7] dst_sel, [12:10] src_sel, [14:13] pair_sel,
    // [16:15] cond, [19:17] sub_op, [22:20] bit_index, [23] mem_operand,
    // [24] undefined, [31:25] zero
    output logic [gbdec_pkg::TDATA_W-1:0]    o_m_tdata
);
    import gbdec_pkg::*;

    t_dec_result w_dec;
    t_dec_result r_out;
    t_dec_result r_skid;
    logic        r_out_valid;
    logic        r_skid_valid;
    logic        w_accept;
    logic        w_out_free;

    assign w_dec      = gbdec_decode(i_s_tdata, i_s_tuser);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_out_free) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= w_accept;
                    if (w_accept) r_out <= w_dec;
                end
            end else if (w_accept) begin
                // receiver stalled: park the new item
                r_skid       <= w_dec;
                r_skid_valid <= 1'b1;
            end
        end
    end

    assign o_s_tready = i_rst_n && !r_skid_valid;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(TDATA_W-RES_W){1'b0}}, r_out};

endmodule

`default_nettype wire
